>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// pre holds -> post holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> sv/fsse_pkg.sv
// Shared widths, register codes and pipeline control types of the same-size FIR.
`default_nettype none

package fsse_pkg;
	localparam int SAMPLE_W       = 16;
	localparam int TAP_W          = 16;
	localparam int PROD_W         = 32;
	localparam int OUT_W          = 35;
	localparam int COUNT_W        = 4;
	localparam int CFG_W          = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int TAP_REGS       = 4;
	localparam int MAX_TAPS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_PAD_MODE  = 3'd1,
		REG_TAPS_01   = 3'd2,
		REG_TAPS_23   = 3'd3,
		REG_TAPS_45   = 3'd4,
		REG_TAPS_67   = 3'd5
	} fsse_reg_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_out;
	} fsse_adv_t;
endpackage

`default_nettype wire

>>> sv/fsse_cell.sv
// One filter cell: a history stage of the sample line plus the multiplier of one tap.
`default_nettype none

module fsse_cell (
	input  logic                                   clk,
	input  logic                                   shift,
	input  logic signed [fsse_pkg::SAMPLE_W-1:0]   sample_in,
	output logic signed [fsse_pkg::SAMPLE_W-1:0]   sample_out,
	input  fsse_pkg::fsse_adv_t                    adv,
	input  logic signed [fsse_pkg::SAMPLE_W-1:0]   operand,
	input  logic signed [fsse_pkg::TAP_W-1:0]      tap,
	output logic signed [fsse_pkg::PROD_W-1:0]     product
);
	import fsse_pkg::*;

	logic signed [SAMPLE_W-1:0] hist_q;
	logic signed [SAMPLE_W-1:0] operand_s1;
	logic signed [PROD_W-1:0]   product_s2;

	always_ff @(posedge clk) begin
		if (shift) begin
			hist_q <= sample_in;
		end
		if (adv.en_s1) begin
			operand_s1 <= operand;
		end
		if (adv.en_s2) begin
			product_s2 <= PROD_W'(operand_s1) * PROD_W'(tap);
		end
	end

	assign sample_out = hist_q;
	assign product    = product_s2;
endmodule

`default_nettype wire

>>> sv/fsse_adder_tree.sv
// Two-level registered adder tree that sums the cell products into the result.
`default_nettype none

module fsse_adder_tree #(
	parameter int MAX_TAPS = fsse_pkg::MAX_TAPS_DEF
) (
	input  logic                                 clk,
	input  fsse_pkg::fsse_adv_t                  adv,
	input  logic signed [fsse_pkg::PROD_W-1:0]   products [MAX_TAPS],
	output logic signed [fsse_pkg::OUT_W-1:0]    sum
);
	import fsse_pkg::*;

	localparam int PAIRS = (MAX_TAPS + 1) / 2;

	logic signed [PROD_W:0]   pair_s3 [PAIRS];
	logic signed [OUT_W-1:0]  total_d;
	logic signed [OUT_W-1:0]  sum_q;

	for (genvar k = 0; k < PAIRS; k++) begin : g_pair
		if (2 * k + 1 < MAX_TAPS) begin : g_two
			always_ff @(posedge clk) begin
				if (adv.en_s3) begin
					pair_s3[k] <= (PROD_W + 1)'(products[2 * k])
						+ (PROD_W + 1)'(products[2 * k + 1]);
				end
			end
		end else begin : g_one
			always_ff @(posedge clk) begin
				if (adv.en_s3) begin
					pair_s3[k] <= (PROD_W + 1)'(products[2 * k]);
				end
			end
		end
	end

	always_comb begin
		total_d = '0;
		for (int k = 0; k < PAIRS; k++) begin
			total_d = total_d + OUT_W'(pair_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_out) begin
			sum_q <= total_d;
		end
	end

	assign sum = sum_q;
endmodule

`default_nettype wire

>>> sv/fir_same_size_edge_padded.sv
// Top level of the same-size, edge-padded FIR correlator.
// Takes one signed sample per cycle unless in_stall is high, and gives one result per
// sample, same length as the input sequence, with the tap window centered at (taps-1)/2.
// An issued sample's result passes the registered stages operand capture, per-tap multiply
// in each cell, pair adds and final add into the output register. A sample marked last
// flushes every result still owed, up to MAX_TAPS-(MAX_TAPS-1)/2 of them, one per cycle
// unless the output stalls, and the input stays stalled until the last of them is issued.
// A stall on the output backs up through the four pipeline stages to reach the input.
// The user writes configuration only while the block is empty; no check enforces it.
`default_nettype none
`include "assert_macros.svh"

module fir_same_size_edge_padded #(
	parameter int MAX_TAPS   = fsse_pkg::MAX_TAPS_DEF,
	parameter int COUNT_BITS = fsse_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [fsse_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fsse_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [fsse_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  last_sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [fsse_pkg::OUT_W-1:0]     filtered,
	output logic                                  last_result
);
	import fsse_pkg::*;

	localparam int DW      = $clog2(MAX_TAPS + 1) + 2;
	localparam int PW      = $clog2(MAX_TAPS + 1);
	localparam int IDX_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int MAX_LAG = MAX_TAPS - 1 - (MAX_TAPS - 1) / 2;
	localparam logic signed [DW-1:0] ZERO = '0;
	localparam logic signed [DW-1:0] ONE  = DW'(1);

	logic [COUNT_W-1:0]         tap_count_q;
	logic                       pad_mode_q;
	logic [CFG_W-1:0]           tap_regs_q [TAP_REGS];

	logic signed [TAP_W-1:0]    taps      [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist      [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] chain_in  [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] view      [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] operand_d [MAX_TAPS];
	logic [IDX_W:0]             sel       [MAX_TAPS];
	logic signed [PROD_W-1:0]   products  [MAX_TAPS];

	fsse_adv_t                  adv;
	logic                       valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                       last_s1, last_s2, last_s3, last_result_q;
	logic [PW-1:0]              pending_q;
	logic [PW-1:0]              pview;
	logic [COUNT_BITS-1:0]      emitted_q;
	logic                       flushing_q;
	logic                       accept, issue, flush_mode, final_o;
	logic [COUNT_W-1:0]         n_eff;
	logic signed [DW-1:0]       n_s, off_s, lag_s, p_s, i_s;

	function automatic logic [IDX_W:0] tap_select(
		input logic signed [DW-1:0] d,
		input logic signed [DW-1:0] p,
		input logic signed [DW-1:0] off,
		input logic signed [DW-1:0] i_lim,
		input logic                 pad
	);
		logic                 low;
		logic                 high;
		logic                 take;
		logic signed [DW-1:0] r;
		logic signed [DW-1:0] idx;
		low  = (d < ZERO) && (i_lim < -d);
		high = (d >= p);
		r    = d;
		take = 1'b1;
		if (low || high) begin
			if (!pad) begin
				take = 1'b0;
			end else begin
				r = low ? d + off : d - off;
				if (r > p - ONE) begin
					r = p - ONE;
				end
				if (r < -i_lim) begin
					r = -i_lim;
				end
			end
		end
		idx = p - ONE - r;
		return {take, idx[IDX_W-1:0]};
	endfunction

	assign adv.en_out = !out_valid_q || !out_stall;
	assign adv.en_s3  = !valid_s3 || adv.en_out;
	assign adv.en_s2  = !valid_s2 || adv.en_s3;
	assign adv.en_s1  = !valid_s1 || adv.en_s2;

	assign in_stall = flushing_q || !adv.en_s1;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (tap_count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (tap_count_q > COUNT_W'(MAX_TAPS)) begin
			n_eff = COUNT_W'(MAX_TAPS);
		end else begin
			n_eff = tap_count_q;
		end
	end

	assign n_s   = $signed(DW'(n_eff));
	assign off_s = (n_s - ONE) >>> 1;
	assign lag_s = n_s - ONE - off_s;
	assign pview = accept ? pending_q + PW'(1) : pending_q;
	assign p_s   = $signed(DW'(pview));
	assign i_s   = (emitted_q >= COUNT_BITS'(MAX_TAPS)) ? $signed(DW'(MAX_TAPS))
		: $signed(DW'(emitted_q));

	assign flush_mode = flushing_q || (accept && last_sample);
	assign issue      = adv.en_s1 && ((accept && (last_sample || p_s > lag_s))
		|| (flushing_q && pending_q != '0));
	assign final_o    = flush_mode && (pview == PW'(1));

	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign chain_in[j] = sample;
		end else begin : g_body
			assign chain_in[j] = hist[j - 1];
		end
		assign taps[j]      = $signed(tap_regs_q[j / 2][(j % 2) * TAP_W +: TAP_W]);
		assign view[j]      = accept ? chain_in[j] : hist[j];
		assign sel[j]       = tap_select($signed(DW'(j)) - off_s, p_s, off_s, i_s, pad_mode_q);
		assign operand_d[j] = (sel[j][IDX_W] && ($signed(DW'(j)) < n_s))
			? view[sel[j][IDX_W-1:0]] : '0;

		fsse_cell u_cell (
			.clk        (clk),
			.shift      (accept),
			.sample_in  (chain_in[j]),
			.sample_out (hist[j]),
			.adv        (adv),
			.operand    (operand_d[j]),
			.tap        (taps[j]),
			.product    (products[j])
		);
	end

	fsse_adder_tree #(
		.MAX_TAPS (MAX_TAPS)
	) u_adder (
		.clk      (clk),
		.adv      (adv),
		.products (products),
		.sum      (filtered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= COUNT_W'(1);
			pad_mode_q  <= 1'b0;
			for (int k = 0; k < TAP_REGS; k++) begin
				tap_regs_q[k] <= '0;
			end
			pending_q   <= '0;
			emitted_q   <= '0;
			flushing_q  <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (fsse_reg_t'(cfg_index))
					REG_TAP_COUNT: tap_count_q   <= cfg_data[COUNT_W-1:0];
					REG_PAD_MODE:  pad_mode_q    <= cfg_data[0];
					REG_TAPS_01:   tap_regs_q[0] <= cfg_data;
					REG_TAPS_23:   tap_regs_q[1] <= cfg_data;
					REG_TAPS_45:   tap_regs_q[2] <= cfg_data;
					REG_TAPS_67:   tap_regs_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (issue) begin
				if (final_o) begin
					pending_q  <= '0;
					emitted_q  <= '0;
					flushing_q <= 1'b0;
				end else begin
					pending_q  <= pview - PW'(1);
					emitted_q  <= emitted_q + COUNT_BITS'(1);
					flushing_q <= flush_mode;
				end
			end else if (accept) begin
				pending_q <= pview;
			end
			if (adv.en_s1) begin
				valid_s1 <= issue;
			end
			if (adv.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv.en_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			last_s1 <= final_o;
		end
		if (adv.en_s2) begin
			last_s2 <= last_s1;
		end
		if (adv.en_s3) begin
			last_s3 <= last_s2;
		end
		if (adv.en_out) begin
			last_result_q <= last_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign last_result = last_result_q;

	`ASSERT_IMPL(a_pending_bound, clk, arst_n, 1'b1, pending_q <= PW'(MAX_LAG),
		"owed results exceed the window lag")
	`ASSERT_IMPL(a_last_issues, clk, arst_n, accept && last_sample, issue && flush_mode,
		"last sample transfer did not issue a result")
	`ASSERT_NEXT(a_final_clears, clk, arst_n, issue && final_o,
		pending_q == '0 && emitted_q == '0 && !flushing_q,
		"sequence counters not cleared after final result")
	`ASSERT_IMPL(a_flush_owed, clk, arst_n, flushing_q, pending_q != '0,
		"flush active with no result owed")
endmodule

`default_nettype wire
